// ===== sv/smbs_pkg.sv =====
// ----------------------------------------------------------------------------
// smbs_pkg
// Shared widths, register indexes and stream field positions for the SPI
// master byte shifter.
// ----------------------------------------------------------------------------
package smbs_pkg;

    localparam int BYTE_W       = 8;
    localparam int MODE_W       = 2;
    localparam int HALF_W       = 8;
    localparam int BIT_COUNT_W  = 4;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 8;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 16;

    localparam logic [BIT_COUNT_W-1:0] BITS_PER_BYTE = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPI_MODE    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD = 1'd1;

    localparam logic [MODE_W-1:0] SPI_MODE_RESET = 2'd0;
    localparam logic [HALF_W-1:0] HALF_RESET     = 8'd1;

    // input tdata bit positions
    localparam int IN_START_POS  = 0;
    localparam int IN_TX_LSB     = 1;
    localparam int IN_SELECT_POS = 9;
    localparam int IN_MISO_POS   = 10;

    // output tdata bit positions
    localparam int OUT_SCK_POS      = 0;
    localparam int OUT_MOSI_POS     = 1;
    localparam int OUT_CS_N_POS     = 2;
    localparam int OUT_RX_LSB       = 3;
    localparam int OUT_RX_MSB       = 10;
    localparam int OUT_RX_VALID_POS = 11;
    localparam int OUT_READY_POS    = 12;

    typedef struct packed {
        logic              ready_res;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              chip_select_n;
        logic              mosi;
        logic              sck;
    } t_result;

endpackage

// ===== sv/spi_master_byte_shifter.sv =====
// ----------------------------------------------------------------------------
// spi_master_byte_shifter
// SPI master, one byte in flight, MSB first, modes 0 to 3.
// ----------------------------------------------------------------------------
// Usage:
//   Each transfer on the s_axis channel is one base tick of the bit timer.
//   It carries the MISO level and, while the shifter is idle, an optional
//   start with the byte to send and a chip-select request; tlast marks the
//   final byte of a message. Each tick yields one transfer on m_axis with
//   SCK, MOSI, CS_n, the ready flag and, on the eighth trailing SCK edge,
//   the received byte with rx_valid set and tlast echoing the message mark.
//   Configuration (mode, SCK half period in ticks) is for the user to write
//   via the cfg port while idle (unenforced); it applies from the next tick.
// Timing:
//   A tick's result is registered; m_axis shows it in the next cycle.
//   One tick per cycle is sustained while m_axis_tready is high; the bound
//   is the single output register.
// Reset and stall:
//   Reset empties the output register, leaves the shifter idle, releases
//   CS_n and loads mode 0 with a half period of one tick. While m_axis
//   stalls, the output register holds and s_axis_tready drops once it is
//   full.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter
    import smbs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_req, tx_byte[7:0], select_now, miso, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sck, mosi, chip_select_n, rx_byte[7:0], rx_valid, ready_res, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    logic [MODE_W-1:0]      r_spi_mode;
    logic [HALF_W-1:0]      r_half;
    logic                   r_busy;
    logic [BIT_COUNT_W-1:0] r_bit_count;
    logic [HALF_W-1:0]      r_tick_count;
    logic                   r_clock_level;
    logic [BYTE_W-1:0]      r_out_shift;
    logic [BYTE_W-1:0]      r_in_shift;
    logic                   r_select_level;
    logic                   r_last_mark;
    logic                   r_out_valid;
    t_result                r_result;
    logic                   r_rx_last;

    logic                   n_busy;
    logic [BIT_COUNT_W-1:0] n_bit_count;
    logic [HALF_W-1:0]      n_tick_count;
    logic                   n_clock_level;
    logic [BYTE_W-1:0]      n_out_shift;
    logic [BYTE_W-1:0]      n_in_shift;
    logic                   n_select_level;
    logic                   n_last_mark;
    t_result                n_result;
    logic                   n_rx_last;

    logic                   w_accept;
    logic                   w_start;
    logic [BYTE_W-1:0]      w_tx;
    logic                   w_select;
    logic                   w_miso;
    logic                   w_cpol;
    logic                   w_cpha;
    logic [HALF_W-1:0]      w_half;
    logic                   w_tick_done;
    logic                   w_leading;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_start  = s_axis_tdata[IN_START_POS];
    assign w_tx     = s_axis_tdata[IN_TX_LSB +: BYTE_W];
    assign w_select = s_axis_tdata[IN_SELECT_POS];
    assign w_miso   = s_axis_tdata[IN_MISO_POS];

    assign w_cpol      = r_spi_mode[1];
    assign w_cpha      = r_spi_mode[0];
    assign w_half      = (r_half == '0) ? HALF_W'(1) : r_half;
    assign w_tick_done = ({1'b0, r_tick_count} + (HALF_W+1)'(1)) >= {1'b0, w_half};
    assign w_leading   = (r_clock_level == w_cpol);

    always_comb begin
        n_busy         = r_busy;
        n_bit_count    = r_bit_count;
        n_tick_count   = r_tick_count;
        n_clock_level  = r_clock_level;
        n_out_shift    = r_out_shift;
        n_in_shift     = r_in_shift;
        n_select_level = r_select_level;
        n_last_mark    = r_last_mark;
        n_result       = '0;
        n_rx_last      = 1'b0;

        if (!r_busy) begin
            n_clock_level = w_cpol;
            if (w_start) begin
                n_busy       = 1'b1;
                n_out_shift  = w_tx;
                n_in_shift   = '0;
                n_bit_count  = '0;
                n_tick_count = '0;
                n_last_mark  = s_axis_tlast;
                if (w_select) begin
                    n_select_level = 1'b0;
                end
            end
        end else if (w_tick_done) begin
            n_tick_count  = '0;
            n_clock_level = !r_clock_level;
            if (w_leading) begin
                if (!w_cpha) begin
                    n_in_shift = {r_in_shift[BYTE_W-2:0], w_miso};
                end else if (r_bit_count != '0) begin
                    n_out_shift = {r_out_shift[BYTE_W-2:0], 1'b0};
                end
            end else begin
                if (w_cpha) begin
                    n_in_shift = {r_in_shift[BYTE_W-2:0], w_miso};
                end
                n_bit_count = r_bit_count + BIT_COUNT_W'(1);
                if (n_bit_count >= BITS_PER_BYTE) begin
                    n_busy            = 1'b0;
                    n_bit_count       = '0;
                    n_result.rx_valid = 1'b1;
                    n_result.rx_byte  = n_in_shift;
                    n_rx_last         = r_last_mark;
                end else if (!w_cpha) begin
                    n_out_shift = {r_out_shift[BYTE_W-2:0], 1'b0};
                end
            end
        end else begin
            n_tick_count = r_tick_count + HALF_W'(1);
        end

        n_result.sck           = n_clock_level;
        n_result.mosi          = n_out_shift[BYTE_W-1];
        n_result.chip_select_n = n_select_level;
        n_result.ready_res     = !r_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spi_mode     <= SPI_MODE_RESET;
            r_half         <= HALF_RESET;
            r_busy         <= 1'b0;
            r_bit_count    <= '0;
            r_tick_count   <= '0;
            r_clock_level  <= 1'b0;
            r_out_shift    <= '0;
            r_in_shift     <= '0;
            r_select_level <= 1'b1;
            r_last_mark    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SPI_MODE:    r_spi_mode <= i_cfg_data[MODE_W-1:0];
                    CFG_HALF_PERIOD: r_half     <= i_cfg_data[HALF_W-1:0];
                    default:         r_half     <= r_half;
                endcase
            end
            if (w_accept) begin
                r_busy         <= n_busy;
                r_bit_count    <= n_bit_count;
                r_tick_count   <= n_tick_count;
                r_clock_level  <= n_clock_level;
                r_out_shift    <= n_out_shift;
                r_in_shift     <= n_in_shift;
                r_select_level <= n_select_level;
                r_last_mark    <= n_last_mark;
                r_out_valid    <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result  <= n_result;
            r_rx_last <= n_rx_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - $bits(t_result))'(0), r_result};
    assign m_axis_tlast  = r_rx_last;

endmodule

// ===== sv/smbs_checker.sv =====
// ----------------------------------------------------------------------------
// smbs_checker
// Port-level checks for the SPI master byte shifter, bound to the top level.
// ----------------------------------------------------------------------------
module smbs_checker
    import smbs_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_last_only_with_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_RX_VALID_POS] |-> !m_axis_tlast)
        else $error("tlast without received byte");

    a_rx_zero_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_RX_VALID_POS]
            |-> m_axis_tdata[OUT_RX_MSB:OUT_RX_LSB] == '0)
        else $error("rx byte set without rx_valid");

    a_select_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[OUT_CS_N_POS]
            |=> !m_axis_tvalid || !m_axis_tdata[OUT_CS_N_POS])
        else $error("chip select released");

    a_ready_when_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind spi_master_byte_shifter smbs_checker u_smbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/tb_spi_master_byte_shifter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spi_master_byte_shifter
// Drives base ticks into the SPI byte shifter in all four modes and over a
// range of SCK half periods, predicts every output tick in the bench and
// checks each m_axis transfer field by field against the oldest prediction.
// The sender runs in bursts with gaps and the receiver stalls on its own
// pattern; configuration changes happen only with no result outstanding.
// ----------------------------------------------------------------------------
module tb_spi_master_byte_shifter;
    import smbs_pkg::*;

    typedef struct packed {
        t_result data;
        logic    rx_last;
    } t_tick_expect;

    typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PERIODIC} t_rx_style;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // start_req, tx_byte[7:0], select_now, miso, zero fill
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // sck, mosi, chip_select_n, rx_byte[7:0], rx_valid, ready_res, zero fill
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // shifter state as predicted by the bench
    logic [MODE_W-1:0]      cfg_mode;
    logic [HALF_W-1:0]      cfg_half;
    logic                   sh_busy;
    logic [BIT_COUNT_W-1:0] sh_bits;
    logic [HALF_W-1:0]      sh_ticks;
    logic                   sh_sck;
    logic [BYTE_W-1:0]      sh_tx;
    logic [BYTE_W-1:0]      sh_rx;
    logic                   sh_cs_n;
    logic                   sh_last;

    t_tick_expect pending_ticks[$];
    int           mismatch_count;
    int           result_index;
    int           burst_left;
    t_rx_style    rx_style;
    int           rx_run;

    spi_master_byte_shifter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void reset_shifter_model();
        cfg_mode = SPI_MODE_RESET;
        cfg_half = HALF_RESET;
        sh_busy  = 1'b0;
        sh_bits  = '0;
        sh_ticks = '0;
        sh_sck   = 1'b0;
        sh_tx    = '0;
        sh_rx    = '0;
        sh_cs_n  = 1'b1;
        sh_last  = 1'b0;
    endfunction

    // advance the shifter by one base tick and queue the tick's outputs
    function automatic void advance_shifter(input logic start, input logic [BYTE_W-1:0] tx,
                                            input logic sel, input logic last,
                                            input logic miso);
        logic         cpol;
        logic         cpha;
        logic         leading;
        int unsigned  half;
        t_tick_expect e;
        cpol = cfg_mode[1];
        cpha = cfg_mode[0];
        half = (cfg_half == '0) ? 1 : cfg_half;
        e = '0;
        e.data.ready_res = ~sh_busy;
        if (!sh_busy) begin
            sh_sck = cpol;
            if (start) begin
                sh_busy  = 1'b1;
                sh_tx    = tx;
                sh_rx    = '0;
                sh_bits  = '0;
                sh_ticks = '0;
                sh_last  = last;
                if (sel) begin
                    sh_cs_n = 1'b0;
                end
            end
        end else if (int'(sh_ticks) + 1 >= half) begin
            leading  = (sh_sck == cpol);
            sh_ticks = '0;
            sh_sck   = ~sh_sck;
            if (leading) begin
                if (!cpha) begin
                    sh_rx = {sh_rx[BYTE_W-2:0], miso};
                end else if (sh_bits != '0) begin
                    sh_tx = sh_tx << 1;
                end
            end else begin
                if (cpha) begin
                    sh_rx = {sh_rx[BYTE_W-2:0], miso};
                end
                sh_bits = sh_bits + 1'b1;
                if (sh_bits >= BITS_PER_BYTE) begin
                    sh_busy          = 1'b0;
                    sh_bits          = '0;
                    e.data.rx_valid  = 1'b1;
                    e.data.rx_byte   = sh_rx;
                    e.rx_last        = sh_last;
                end else if (!cpha) begin
                    sh_tx = sh_tx << 1;
                end
            end
        end else begin
            sh_ticks = sh_ticks + 1'b1;
        end
        e.data.sck           = sh_sck;
        e.data.mosi          = sh_tx[BYTE_W-1];
        e.data.chip_select_n = sh_cs_n;
        pending_ticks.push_back(e);
    endfunction

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("%0t: result %0d %s got %h expected %h", $realtime, result_index, what,
                     got, want);
        end
    endtask

    task automatic send_tick(input logic start, input logic [BYTE_W-1:0] tx, input logic sel,
                             input logic last, input logic miso);
        logic [IN_TDATA_W-1:0] word;
        int                    gap;
        word = '0;
        word[IN_START_POS]          = start;
        word[IN_TX_LSB +: BYTE_W]   = tx;
        word[IN_SELECT_POS]         = sel;
        word[IN_MISO_POS]           = miso;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        advance_shifter(start, tx, sel, last, miso);
        burst_left--;
    endtask

    task automatic pause_until_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_ticks.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (index == CFG_SPI_MODE) begin
            cfg_mode = value[MODE_W-1:0];
        end else begin
            cfg_half = value;
        end
    endtask

    // send idle ticks until the byte in flight is done
    task automatic finish_transfer();
        while (sh_busy) begin
            send_tick(1'b0, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_random_ticks(input int count);
        logic              start;
        logic [BYTE_W-1:0] tx;
        for (int i = 0; i < count; i++) begin
            if (!sh_busy) begin
                start = ($urandom_range(0, 9) < 8);
            end else begin
                start = ($urandom_range(0, 4) == 0);
            end
            case ($urandom_range(0, 7))
                0: tx = 8'h00;
                1: tx = 8'hFF;
                default: tx = 8'($urandom_range(0, 255));
            endcase
            send_tick(start, tx, ($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
            if ($urandom_range(0, 399) == 0) begin
                pause_until_drained();
            end
        end
    endtask

    task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [HALF_W-1:0] half,
                             input int count);
        finish_transfer();
        pause_until_drained();
        write_cfg(CFG_SPI_MODE, {6'($urandom_range(0, 63)), mode});
        write_cfg(CFG_HALF_PERIOD, half);
        run_random_ticks(count);
    endtask

    task automatic test_reset_state();
        send_tick(1'b0, 8'hFF, 1'b0, 1'b1, 1'b1);
        send_tick(1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
    endtask

    // one byte without chip select, with a start while busy that must be dropped, then a byte with chip select
    task automatic test_directed_byte();
        send_tick(1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
        for (int i = 0; i < 16; i++) begin
            if (i == 4) begin
                send_tick(1'b1, 8'hFF, 1'b1, 1'b0, 1'b1);
            end else begin
                send_tick(1'b0, 8'hFF, 1'b0, 1'b0, 1'b1);
            end
        end
        send_tick(1'b1, 8'hA5, 1'b1, 1'b1, 1'b0);
        finish_transfer();
    endtask

    task automatic test_mode_sweep();
        for (int m = 0; m < 4; m++) begin
            run_phase(MODE_W'(m), 8'd1, 120);
        end
        run_phase(2'd0, 8'd2, 120);
        run_phase(2'd3, 8'd3, 120);
    endtask

    task automatic test_zero_half_period();
        run_phase(2'($urandom_range(0, 3)), 8'd0, 100);
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            run_phase(2'($urandom_range(0, 3)), 8'($urandom_range(1, 6)), 80);
        end
        run_phase(2'($urandom_range(0, 3)), 8'($urandom_range(7, 20)), 120);
    endtask

    // slowest clock, then cut the half period below the running count mid-byte
    task automatic test_slow_clock_cut_short();
        finish_transfer();
        pause_until_drained();
        write_cfg(CFG_SPI_MODE, {6'd0, 2'($urandom_range(0, 3))});
        write_cfg(CFG_HALF_PERIOD, 8'd255);
        send_tick(1'b1, 8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        run_random_ticks(250);
        pause_until_drained();
        write_cfg(CFG_HALF_PERIOD, 8'd1);
        finish_transfer();
        run_random_ticks(80);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_SPI_MODE;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        mismatch_count = 0;
        burst_left     = 0;
        reset_shifter_model();
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_directed_byte();
        test_mode_sweep();
        test_zero_half_period();
        test_random_settings();
        test_slow_clock_cut_short();

        pause_until_drained();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb_spi_master_byte_shifter: PASS");
        end else begin
            $display("tb_spi_master_byte_shifter: FAIL");
        end
        $finish;
    end

    initial begin
        m_axis_tready = 1'b0;
        rx_run        = 0;
        rx_style      = RX_FREE;
        forever begin
            @(negedge i_clk);
            if (rx_run == 0) begin
                rx_style = t_rx_style'($urandom_range(0, 2));
                rx_run   = $urandom_range(10, 120);
            end
            rx_run--;
            case (rx_style)
                RX_FREE:   m_axis_tready <= 1'b1;
                RX_RANDOM: m_axis_tready <= ($urandom_range(0, 2) != 0);
                default:   m_axis_tready <= (rx_run % 4 != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_result
        t_result      got;
        t_tick_expect want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[OUT_READY_POS:0]);
            if (pending_ticks.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata[BYTE_W-1:0], 8'h00);
            end else begin
                want = pending_ticks.pop_front();
                if (got.sck !== want.data.sck)
                    report_mismatch("sck", BYTE_W'(got.sck), BYTE_W'(want.data.sck));
                if (got.mosi !== want.data.mosi)
                    report_mismatch("mosi", BYTE_W'(got.mosi), BYTE_W'(want.data.mosi));
                if (got.chip_select_n !== want.data.chip_select_n)
                    report_mismatch("chip_select_n", BYTE_W'(got.chip_select_n),
                                    BYTE_W'(want.data.chip_select_n));
                if (got.rx_byte !== want.data.rx_byte)
                    report_mismatch("rx_byte", got.rx_byte, want.data.rx_byte);
                if (got.rx_valid !== want.data.rx_valid)
                    report_mismatch("rx_valid", BYTE_W'(got.rx_valid),
                                    BYTE_W'(want.data.rx_valid));
                if (got.ready_res !== want.data.ready_res)
                    report_mismatch("ready_res", BYTE_W'(got.ready_res),
                                    BYTE_W'(want.data.ready_res));
                if (m_axis_tlast !== want.rx_last)
                    report_mismatch("rx_last", BYTE_W'(m_axis_tlast), BYTE_W'(want.rx_last));
                if (m_axis_tdata[OUT_TDATA_W-1:OUT_READY_POS+1] !== '0)
                    report_mismatch("tdata fill",
                                    BYTE_W'(m_axis_tdata[OUT_TDATA_W-1:OUT_READY_POS+1]),
                                    8'h00);
            end
            result_index++;
        end
    end

    initial begin
        result_index = 0;
        #10_000_000;
        $display("tb_spi_master_byte_shifter: FAIL");
        $finish;
    end

endmodule
